@@ sv/lphf_pkg.sv @@
// shared types and constants for the linear probe hash find-or-insert block
`timescale 1ns / 1ps

package lphf_pkg;

    // fixed field widths of the request and result channels
    localparam int unsigned KEY_IN_W = 32;
    localparam int unsigned SLOT_W   = 8;
    localparam int unsigned STATUS_W = 2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_FOUND    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_HOLD
    } t_state;

endpackage

@@ sv/linear_probe_hash_find_or_insert.sv @@
// top level of the linear probe hash table with find-or-insert
`timescale 1ns / 1ps

// channel   | valid        | stall        | payload
// ----------+--------------+--------------+---------------------------------
// request   | i_in_valid   | o_in_stall   | i_key
// result    | o_out_valid  | i_out_stall  | o_slot, o_status
//
// after reset a clearing pass walks the table, one slot a cycle,
// during which o_in_stall is high
// a request probes 1 to TABLE_SIZE slots from its home slot on, all TABLE_SIZE for a
// full table, and the next request is not taken before it is through; a table size
// that is not a power of two first finds the home slot as the key remainder, one
// 4-bit key digit a cycle reduced against constant multiples of the size
// the single read port of the slot memory sets the pace: one slot probed per cycle
// a finished result waits in the output register, so a stalled result does not keep
// the next request from being taken; only a second finished result waits for it

module linear_probe_hash_find_or_insert #(
    parameter int unsigned TABLE_SIZE = 256,
    parameter int unsigned KEY_WIDTH  = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [lphf_pkg::KEY_IN_W-1:0]    i_key,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [lphf_pkg::SLOT_W-1:0]      o_slot,
    output logic [lphf_pkg::STATUS_W-1:0]    o_status
);

    // slot index, probe count and key digit index widths
    localparam int unsigned IDX_W   = $clog2(TABLE_SIZE);
    localparam int unsigned CNT_W   = $clog2(TABLE_SIZE + 1);
    localparam int unsigned NUM_DIG = (KEY_WIDTH + 3) / 4;
    localparam int unsigned DIG_W   = $clog2(NUM_DIG);
    localparam int unsigned PAD_W   = NUM_DIG * 4;
    localparam int unsigned REM_W   = IDX_W + 4;
    localparam bit          IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_SIZE - 1);
    localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(TABLE_SIZE);
    localparam logic [DIG_W-1:0] TOP_DIG   = DIG_W'(NUM_DIG - 1);

    // control registers
    lphf_pkg::t_state r_state, n_state;
    logic [IDX_W-1:0] r_issue_addr, n_issue_addr;   // slot being read, also the clear pointer
    logic [CNT_W-1:0] r_issued, n_issued;           // slots read so far for this request
    logic             r_cmp_vld, n_cmp_vld;         // read data is a probe to compare
    logic             r_out_valid, n_out_valid;

    // payload registers
    logic [KEY_WIDTH-1:0]           r_key, n_key;
    logic [IDX_W-1:0]               r_cmp_addr, n_cmp_addr;
    logic [IDX_W-1:0]               r_rem, n_rem;
    logic [DIG_W-1:0]               r_dig, n_dig;
    logic [lphf_pkg::SLOT_W-1:0]    r_res_slot, n_res_slot;
    logic [lphf_pkg::STATUS_W-1:0]  r_res_status, n_res_status;
    logic [lphf_pkg::SLOT_W-1:0]    r_out_slot, n_out_slot;
    logic [lphf_pkg::STATUS_W-1:0]  r_out_status, n_out_status;

    // slot memory: valid flag on top of the stored key
    logic [KEY_WIDTH:0] r_mem [TABLE_SIZE];
    logic [KEY_WIDTH:0] r_rd_data;

    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    logic [KEY_WIDTH:0] w_wdata;

    logic [63:0]          w_in_ext;
    logic [KEY_WIDTH-1:0] w_key_in;
    logic [63:0]          w_key_in64;
    logic [IDX_W-1:0]     w_next_addr;
    logic                 w_issuing;
    logic [PAD_W-1:0]     w_key_pad;
    logic [3:0]           w_digit;
    logic [REM_W-1:0]     w_rem_val;
    logic [REM_W-1:0]     w_rem_mult;
    logic [REM_W-1:0]     w_rem_diff;
    logic [IDX_W-1:0]     w_rem_next;

    // only the low KEY_WIDTH bits of the request key take part
    assign w_in_ext   = {32'd0, i_key};
    assign w_key_in   = w_in_ext[KEY_WIDTH-1:0];
    assign w_key_in64 = 64'(w_key_in);

    // wrapping slot increment, shared by the clearing pass and the probe walk
    assign w_next_addr = (r_issue_addr == LAST_SLOT) ? '0 : r_issue_addr + IDX_W'(1);
    assign w_issuing   = (r_issued != MAX_CNT);

    // one key digit per cycle, most significant first: the partial remainder
    // shifted up by a digit stays below 16 times the table size, so one
    // subtract of the largest fitting constant multiple brings it back in range
    assign w_key_pad  = PAD_W'(r_key);
    assign w_digit    = w_key_pad[{r_dig, 2'b00} +: 4];
    assign w_rem_val  = {r_rem, w_digit};
    assign w_rem_diff = w_rem_val - w_rem_mult;
    assign w_rem_next = w_rem_diff[IDX_W-1:0];

    always_comb begin
        w_rem_mult = '0;
        for (int k = 1; k < 16; k++) begin
            if (w_rem_val >= REM_W'(k * TABLE_SIZE)) begin
                w_rem_mult = REM_W'(k * TABLE_SIZE);
            end
        end
    end

    assign o_in_stall  = (r_state != lphf_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_slot      = r_out_slot;
    assign o_status    = r_out_status;

    // state register and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lphf_pkg::ST_CLEAR;
            r_issue_addr <= '0;
            r_issued     <= '0;
            r_cmp_vld    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_issue_addr <= n_issue_addr;
            r_issued     <= n_issued;
            r_cmp_vld    <= n_cmp_vld;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_cmp_addr   <= n_cmp_addr;
        r_rem        <= n_rem;
        r_dig        <= n_dig;
        r_res_slot   <= n_res_slot;
        r_res_status <= n_res_status;
        r_out_slot   <= n_out_slot;
        r_out_status <= n_out_status;
    end

    // slot memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[r_issue_addr];
    end

    // sequencer: clear, hash, probe, hand over the result
    always_comb begin
        n_state      = r_state;
        n_issue_addr = r_issue_addr;
        n_issued     = r_issued;
        n_cmp_vld    = r_cmp_vld;
        n_out_valid  = r_out_valid;
        n_key        = r_key;
        n_cmp_addr   = r_cmp_addr;
        n_rem        = r_rem;
        n_dig        = r_dig;
        n_res_slot   = r_res_slot;
        n_res_status = r_res_status;
        n_out_slot   = r_out_slot;
        n_out_status = r_out_status;
        w_we         = 1'b0;
        w_waddr      = r_cmp_addr;
        w_wdata      = {1'b1, r_key};

        // result taken downstream
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            lphf_pkg::ST_CLEAR: begin
                // mark one slot empty per cycle
                w_we         = 1'b1;
                w_waddr      = r_issue_addr;
                w_wdata      = '0;
                n_issue_addr = w_next_addr;
                if (r_issue_addr == LAST_SLOT) begin
                    n_state = lphf_pkg::ST_IDLE;
                end
            end
            lphf_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_key     = w_key_in;
                    n_cmp_vld = 1'b0;
                    n_issued  = '0;
                    if (IS_POW2) begin
                        // home slot is just the low key bits
                        n_issue_addr = w_key_in64[IDX_W-1:0];
                        n_state      = lphf_pkg::ST_PROBE;
                    end else begin
                        n_rem   = '0;
                        n_dig   = TOP_DIG;
                        n_state = lphf_pkg::ST_HASH;
                    end
                end
            end
            lphf_pkg::ST_HASH: begin
                n_rem = w_rem_next;
                if (r_dig == '0) begin
                    n_issue_addr = w_rem_next;
                    n_state      = lphf_pkg::ST_PROBE;
                end else begin
                    n_dig = r_dig - DIG_W'(1);
                end
            end
            lphf_pkg::ST_PROBE: begin
                // read the next slot ahead while comparing the previous one
                n_cmp_addr = r_issue_addr;
                n_cmp_vld  = w_issuing;
                if (w_issuing) begin
                    n_issue_addr = w_next_addr;
                    n_issued     = r_issued + CNT_W'(1);
                end
                if (r_cmp_vld) begin
                    if (!r_rd_data[KEY_WIDTH]) begin
                        // empty slot: claim it
                        w_we         = 1'b1;
                        w_waddr      = r_cmp_addr;
                        n_res_slot   = lphf_pkg::SLOT_W'(r_cmp_addr);
                        n_res_status = lphf_pkg::STATUS_INSERTED;
                        n_state      = lphf_pkg::ST_HOLD;
                    end else if (r_rd_data[KEY_WIDTH-1:0] == r_key) begin
                        n_res_slot   = lphf_pkg::SLOT_W'(r_cmp_addr);
                        n_res_status = lphf_pkg::STATUS_FOUND;
                        n_state      = lphf_pkg::ST_HOLD;
                    end
                end else if (!w_issuing) begin
                    // every slot probed, no match and no room
                    n_res_slot   = '0;
                    n_res_status = lphf_pkg::STATUS_FULL;
                    n_state      = lphf_pkg::ST_HOLD;
                end
            end
            lphf_pkg::ST_HOLD: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_slot   = r_res_slot;
                    n_out_status = r_res_status;
                    n_state      = lphf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lphf_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // an accepted request stalls the input in the cycle after it is taken
    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while the previous one is still in work");

    // only defined status codes reach the port
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == lphf_pkg::STATUS_FOUND ||
                         o_status == lphf_pkg::STATUS_INSERTED ||
                         o_status == lphf_pkg::STATUS_FULL))
        else $error("undefined status code on the result");

    // a full table reports slot zero
    a_full_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == lphf_pkg::STATUS_FULL) |-> (o_slot == '0))
        else $error("full result with a nonzero slot");

    // the probe walk never reads more slots than the table holds
    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issued <= MAX_CNT)
        else $error("probe count ran past the table size");

    // the memory is written only by the clearing pass or an insert
    a_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == lphf_pkg::ST_CLEAR ||
                  (r_state == lphf_pkg::ST_PROBE && r_cmp_vld)))
        else $error("slot memory written outside clear or insert");
`endif

endmodule

@@ test/lphf_checker.sv @@
// checker for the hash find-or-insert block: table model, result queue and compare
`timescale 1ns / 1ps

module lphf_checker #(
    parameter int unsigned TABLE_SIZE = 256,
    parameter int unsigned KEY_WIDTH  = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic [lphf_pkg::KEY_IN_W-1:0]    i_key,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic [lphf_pkg::SLOT_W-1:0]      i_slot,
    input  logic [lphf_pkg::STATUS_W-1:0]    i_status,
    output int                               o_mismatches,
    output int                               o_pending,
    output int                               o_found,
    output int                               o_inserted,
    output int                               o_full
);

    localparam logic [lphf_pkg::KEY_IN_W-1:0] KEY_MASK =
        (KEY_WIDTH >= lphf_pkg::KEY_IN_W) ? '1 :
        lphf_pkg::KEY_IN_W'((64'd1 << KEY_WIDTH) - 64'd1);

    typedef struct packed {
        logic [lphf_pkg::SLOT_W-1:0]   slot;
        logic [lphf_pkg::STATUS_W-1:0] status;
    } t_lookup_result;

    logic [lphf_pkg::KEY_IN_W-1:0] stored_key [TABLE_SIZE];
    bit                            occupied   [TABLE_SIZE];
    t_lookup_result                expected_lookups [$];
    t_lookup_result                want;
    int                            results_seen;

    // walk the table from the home slot, stop at the first matching slot or insert on the first free slot
    function automatic t_lookup_result probe_find_or_insert(
        input logic [lphf_pkg::KEY_IN_W-1:0] key);
        logic [lphf_pkg::KEY_IN_W-1:0] k;
        int unsigned                   home;
        int unsigned                   s;
        t_lookup_result                r;
        k        = key & KEY_MASK;
        home     = k % TABLE_SIZE;
        r.slot   = '0;
        r.status = lphf_pkg::STATUS_FULL;
        for (int unsigned n = 0; n < TABLE_SIZE; n++) begin
            s = (home + n) % TABLE_SIZE;
            if (!occupied[s]) begin
                occupied[s]   = 1'b1;
                stored_key[s] = k;
                r.slot        = lphf_pkg::SLOT_W'(s);
                r.status      = lphf_pkg::STATUS_INSERTED;
                return r;
            end
            if (stored_key[s] == k) begin
                r.slot   = lphf_pkg::SLOT_W'(s);
                r.status = lphf_pkg::STATUS_FOUND;
                return r;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] exp_val,
                                   input logic [31:0] act_val);
        o_mismatches++;
        if (o_mismatches <= 10)
            $display("mismatch on result %0d: %s expected %0d got %0d",
                     results_seen, what, exp_val, act_val);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int unsigned i = 0; i < TABLE_SIZE; i++)
                occupied[i] = 1'b0;
            expected_lookups.delete();
            o_mismatches = 0;
            o_found      = 0;
            o_inserted   = 0;
            o_full       = 0;
            results_seen = 0;
        end else begin
            if (i_in_valid && !i_in_stall)
                expected_lookups.push_back(probe_find_or_insert(i_key));
            if (i_out_valid && !i_out_stall) begin
                if (expected_lookups.size() == 0) begin
                    report_mismatch("unexpected result, status", '0, 32'(i_status));
                end else begin
                    want = expected_lookups.pop_front();
                    if (i_slot !== want.slot)
                        report_mismatch("slot", 32'(want.slot), 32'(i_slot));
                    if (i_status !== want.status)
                        report_mismatch("status", 32'(want.status), 32'(i_status));
                    case (want.status)
                        lphf_pkg::STATUS_FOUND:    o_found++;
                        lphf_pkg::STATUS_INSERTED: o_inserted++;
                        default:                   o_full++;
                    endcase
                end
                results_seen++;
            end
        end
        o_pending = expected_lookups.size();
    end

endmodule

@@ test/tb_linear_probe_hash_find_or_insert.sv @@
// testbench top for the hash find-or-insert block: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_linear_probe_hash_find_or_insert;

    localparam int unsigned TABLE_SIZE = 256;
    localparam int unsigned KEY_WIDTH  = 32;

    // random requests per flow-control phase
    localparam int PHASE_REQUESTS  = 300;
    // long receiver hold-off, enough to back the block up into its input
    localparam int HOLD_OFF_CYCLES = 400;
    // covers a full-table probe with the receiver hold-off added to it
    localparam int WATCHDOG_LIMIT  = 5000;
    // settle time after the last result
    localparam int DRAIN_CYCLES    = 20;
    localparam int NUM_DIRECTED    = 12;

    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              i_in_valid  = 1'b0;
    logic [lphf_pkg::KEY_IN_W-1:0]     i_key       = '0;
    logic                              i_out_stall = 1'b0;
    logic                              o_in_stall;
    logic                              o_out_valid;
    logic [lphf_pkg::SLOT_W-1:0]       o_slot;
    logic [lphf_pkg::STATUS_W-1:0]     o_status;

    int mismatches;
    int pending;
    int n_found;
    int n_inserted;
    int n_full;

    // flow-control knobs shared between the stimulus and receiver processes, and the watchdog's quiet count
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    bit hold_req          = 1'b0;
    bit hold_done         = 1'b0;
    int quiet_cycles      = 0;

    // every key offered so far, reused to hit the found path deep in clusters
    logic [lphf_pkg::KEY_IN_W-1:0] offered_keys [$];

    // directed keys: home slot 0 chain, the wrap from slot 255 back to 0,
    // repeats for found, and extreme key values
    logic [lphf_pkg::KEY_IN_W-1:0] directed_keys [NUM_DIRECTED] = '{
        32'h0000_0000,  // empty home slot 0, insert there
        32'h0000_0000,  // found at home
        32'hFFFF_FFFF,  // all ones, home 255
        32'h0000_01FF,  // home 255 taken, wraps to 0, lands on 1
        32'h0000_01FF,  // found after a wrapped probe
        32'h0000_0100,  // home 0, probes past 0 and 1
        32'h8000_0000,  // top bit only, home 0 cluster grows
        32'hAAAA_AAAA,  // alternating bits
        32'h5555_5555,  // the other alternation
        32'hFFFF_FFFF,  // found at 255
        32'h1234_5601,  // home 1 inside the cluster, probes forward
        32'h8000_0000   // found deep in the cluster
    };

    always #5 i_clk = ~i_clk;

    linear_probe_hash_find_or_insert #(
        .TABLE_SIZE (TABLE_SIZE),
        .KEY_WIDTH  (KEY_WIDTH)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_key       (i_key),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_slot      (o_slot),
        .o_status    (o_status)
    );

    lphf_checker #(
        .TABLE_SIZE (TABLE_SIZE),
        .KEY_WIDTH  (KEY_WIDTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_key        (i_key),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_slot       (o_slot),
        .i_status     (o_status),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_found      (n_found),
        .o_inserted   (n_inserted),
        .o_full       (n_full)
    );

    // offer one request, with random idle cycles ahead of it, and hold it
    // until the block takes it; returns at the accepting edge
    task automatic offer_key(input logic [lphf_pkg::KEY_IN_W-1:0] k);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_key      <= k;
        offered_keys.push_back(k);
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // random requests: repeats of old keys, keys packed around a few hot home
    // slots to build long probe chains (one hot spot wraps past slot 255),
    // and fully random keys; the table fills up along the way, so later
    // new keys come back as full
    task automatic random_phase(input int s_pct, input int r_pct, input int count);
        int                            pick;
        logic [lphf_pkg::KEY_IN_W-1:0] k;
        logic [7:0]                    hot;
        sender_idle_pct   = s_pct;
        receiver_idle_pct = r_pct;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 35 && offered_keys.size() > 0) begin
                k = offered_keys[$urandom_range(offered_keys.size() - 1)];
            end else if (pick < 70) begin
                case ($urandom_range(2))
                    0:       hot = 8'h00;
                    1:       hot = 8'h80;
                    default: hot = 8'hF8;
                endcase
                k      = $urandom();
                k[7:0] = hot + 8'($urandom_range(11));
            end else begin
                k = $urandom();
            end
            offer_key(k);
        end
    endtask

    // receiver: random stall per cycle, or one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < receiver_idle_pct);
            end
        end
    end

    // watchdog: cycles with no handshake on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, pending);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        // reset, then the block clears its table on its own with input stalled
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed requests, no idling
        foreach (directed_keys[i])
            offer_key(directed_keys[i]);

        // long receiver hold-off at the start of the first phase, while the
        // table is still sparse and requests finish fast enough to back up
        hold_req = 1'b1;
        random_phase(32, 69, PHASE_REQUESTS);
        random_phase(69, 32, PHASE_REQUESTS);
        random_phase(0, 0, PHASE_REQUESTS);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests: %0d found, %0d inserted, %0d on a full table",
                 offered_keys.size(), n_found, n_inserted, n_full);
        $display("flow control: idle sender and receiver mixes, one %0d-cycle result hold-off",
                 HOLD_OFF_CYCLES);
        if (mismatches == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, pending);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/lphf_pkg.sv
sv/linear_probe_hash_find_or_insert.sv
test/lphf_checker.sv
test/tb_linear_probe_hash_find_or_insert.sv
